/* sv/mrrs_pkg.sv */
// ----------------------------------------------------------------------------
// mrrs_pkg
// Shared types and constants of the multilevel round-robin scheduler: item
// field widths, operation codes, and the control and chain bundles that run
// between the sequencer and the queue cells.
// ----------------------------------------------------------------------------
`default_nettype none

package mrrs_pkg;

   // Field widths of the items
   localparam int TASK_W  = 8;
   localparam int LEVEL_W = 4;
   localparam int SLICE_W = 8;
   localparam int OP_W    = 2;

   // Default sizes
   localparam int DEF_NUM_TASKS       = 256;
   localparam int DEF_NUM_LEVELS      = 8;
   localparam int DEF_TASKS_PER_LEVEL = 64;

   // Widest control fields over the supported parameter ranges
   localparam int LVL_MAX_W = 4;   // up to 16 levels
   localparam int CNT_MAX_W = 9;   // count up to 256
   localparam int IDX_MAX_W = 8;   // slot index up to 255

   localparam logic [OP_W-1:0] OP_RUN    = 2'd0;
   localparam logic [OP_W-1:0] OP_SLEEP  = 2'd1;
   localparam logic [OP_W-1:0] OP_SWITCH = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_WRITE
   } cell_op_type;

   // Broadcast to every cell of the queue row
   typedef struct packed {
      cell_op_type            op;
      logic [LVL_MAX_W-1:0]   level;
      logic [TASK_W-1:0]      task_id;
      logic [CNT_MAX_W-1:0]   count;
      logic [IDX_MAX_W-1:0]   cursor;
   } cell_cmd_type;

   // Passed from one cell to the next, one hop a cycle
   typedef struct packed {
      logic                   found;    // match at this slot or earlier
      logic                   prior;    // match ahead of the cursor
      logic [TASK_W-1:0]      pick;     // entry at the cursor slot
   } cell_chain_type;

endpackage

`default_nettype wire

/* sv/mrrs_cell.sv */
// ----------------------------------------------------------------------------
// mrrs_cell
// One slot position of all level queues. Holds the entry of each level at
// this slot, forwards search and cursor-pick results to its right neighbor,
// and shifts or writes its entry of the selected level.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrs_cell
   import mrrs_pkg::*;
#(
   parameter int NUM_LEVELS = DEF_NUM_LEVELS,
   parameter int CELL_IDX   = 0
) (
   input  wire logic           clock,
   input  wire cell_cmd_type   cmd,
   input  wire cell_chain_type chain_left,
   input  wire logic [TASK_W-1:0] right_ent,
   output      cell_chain_type chain_out,
   output      logic [TASK_W-1:0] ent_out
);

   localparam int LVL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

   localparam logic [CNT_MAX_W-1:0] IDX_C = CNT_MAX_W'(CELL_IDX);
   localparam logic [IDX_MAX_W-1:0] IDX_P = IDX_MAX_W'(CELL_IDX);

   logic [TASK_W-1:0] ent_ff [NUM_LEVELS];
   cell_chain_type    chain_ff;
   cell_chain_type    chain_in;
   logic [LVL_W-1:0]  lvl;
   logic              hit;

   assign lvl     = cmd.level[LVL_W-1:0];
   assign ent_out = ent_ff[lvl];
   assign hit     = (IDX_C < cmd.count) && (ent_out == cmd.task_id);

   always_comb begin
      chain_in.found = chain_left.found | hit;
      chain_in.prior = chain_left.prior | (hit && (IDX_P < cmd.cursor));
      chain_in.pick  = (IDX_P == cmd.cursor) ? ent_out : chain_left.pick;
   end

   always_ff @(posedge clock) begin
      chain_ff <= chain_in;
      case (cmd.op)
         CELL_SHIFT: begin
            // slots at and behind the removed one take the next entry
            if (chain_ff.found) begin
               ent_ff[lvl] <= right_ent;
            end
         end
         CELL_WRITE: begin
            if (IDX_C == cmd.count) begin
               ent_ff[lvl] <= cmd.task_id;
            end
         end
         default: begin
         end
      endcase
   end

   assign chain_out = chain_ff;

endmodule

`default_nettype wire

/* sv/multilevel_round_robin_scheduler.sv */
// ----------------------------------------------------------------------------
// multilevel_round_robin_scheduler
// Multilevel round-robin task scheduler: one ordered queue per level held in
// a row of slot cells, a per-task table of active flag, level and slice, and
// a sequencer for the run, sleep and switch operations.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+---------------------------------
//  req     | in  | req_tvalid / req_tready | op, task_id, new_level, new_slice
//  rsp     | out | rsp_tvalid / rsp_tready | current_task, slice_ticks,
//          |     |                         | load_timer, do_switch, status
//
//  One item at a time. Every queue lookup is a walk down the cell row.
//  After each response the block returns to idle before it takes the next
//  item. After reset a clearing pass zeroes the task table; req_tready stays
//  low until it ends. rsp stalls hold the block in place.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_round_robin_scheduler
   import mrrs_pkg::*;
#(
   parameter int NUM_TASKS       = DEF_NUM_TASKS,
   parameter int NUM_LEVELS      = DEF_NUM_LEVELS,
   parameter int TASKS_PER_LEVEL = DEF_TASKS_PER_LEVEL
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [1:0] op, [9:2] task_id, [13:10] new_level, [21:14] new_slice
   input  wire logic [23:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] current_task, [15:8] slice_ticks, [16] load_timer,
   // [17] do_switch, [18] status
   output      logic [23:0] rsp_tdata
);

   localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int LVX_W   = $clog2(NUM_LEVELS + 1);
   localparam int CNT_W   = $clog2(TASKS_PER_LEVEL + 1);
   localparam int IDX_W   = $clog2(TASKS_PER_LEVEL);
   localparam int TADDR_W = $clog2(NUM_TASKS);
   localparam int NEPAD   = 1 << LVL_W;
   localparam int REC_W   = 1 + LVL_W + SLICE_W;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_RUN_CHK,
      S_RUN_SHIFT,
      S_RUN_INS,
      S_SL_NOW,
      S_SL_SHIFT,
      S_SL_RESEL,
      S_SW_ADV,
      S_FIN_SET,
      S_FIN_GOT,
      S_FIN_SLC,
      S_OUT
   } state_type;

   // ---- task table (active, level, slice) ----
   logic [REC_W-1:0]   task_mem [NUM_TASKS];
   logic [REC_W-1:0]   rec_ff;
   logic [TADDR_W-1:0] mem_ra;
   logic [TADDR_W-1:0] mem_wa;
   logic [REC_W-1:0]   mem_wd;
   logic               mem_we;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         task_mem[mem_wa] <= mem_wd;
      end
      rec_ff <= task_mem[mem_ra];
   end

   logic               rec_act;
   logic [LVL_W-1:0]   rec_lvl;
   logic [SLICE_W-1:0] rec_slc;

   assign rec_act = rec_ff[REC_W-1];
   assign rec_lvl = rec_ff[SLICE_W +: LVL_W];
   assign rec_slc = rec_ff[SLICE_W-1:0];

   // ---- sequencer registers ----
   state_type          state_ff, state_in;
   state_type          ret_ff, ret_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;
   logic [TADDR_W-1:0] clr_ff, clr_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [TASK_W-1:0]  tid_ff, tid_in;
   logic               tok_ff, tok_in;
   logic [LEVEL_W-1:0] lvraw_ff, lvraw_in;
   logic [SLICE_W-1:0] nslc_ff, nslc_in;
   logic [LVL_W-1:0]   lv_ff, lv_in;
   logic [LVL_W-1:0]   lsel_ff, lsel_in;
   logic               had_ff, had_in;
   logic [TASK_W-1:0]  now_ff, now_in;
   logic [LVX_W-1:0]   cl_ff, cl_in;
   logic               chg_ff, chg_in;
   logic [CNT_W-1:0]   cnt_ff [NUM_LEVELS];
   logic [CNT_W-1:0]   cnt_in [NUM_LEVELS];
   logic [IDX_W-1:0]   cur_ff [NUM_LEVELS];
   logic [IDX_W-1:0]   cur_in [NUM_LEVELS];
   logic [TASK_W-1:0]  otask_ff, otask_in;
   logic [SLICE_W-1:0] oslc_ff, oslc_in;
   logic               oload_ff, oload_in;
   logic               osw_ff, osw_in;
   logic               ostat_ff, ostat_in;

   // ---- cell row ----
   cell_cmd_type       cmd;
   cell_chain_type     chain [TASKS_PER_LEVEL + 1];
   logic [TASK_W-1:0]  ent [TASKS_PER_LEVEL + 1];

   assign chain[0]               = '0;
   assign ent[TASKS_PER_LEVEL]   = '0;

   for (genvar k = 0; k < TASKS_PER_LEVEL; k++) begin : g_cell
      mrrs_cell #(
         .NUM_LEVELS (NUM_LEVELS),
         .CELL_IDX   (k)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .chain_left (chain[k]),
         .right_ent  (ent[k+1]),
         .chain_out  (chain[k+1]),
         .ent_out    (ent[k])
      );
   end

   cell_chain_type row_end;
   assign row_end = chain[TASKS_PER_LEVEL];

   // ---- level status ----
   logic [NEPAD-1:0]   nonempty;
   logic [LVX_W-1:0]   resel_lvl;
   logic               cl_ok;
   logic               cl_has;
   logic [CNT_W-1:0]   cnt_sel;
   logic [IDX_W-1:0]   cur_sel;

   always_comb begin
      nonempty = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         nonempty[i] = (cnt_ff[i] != '0);
      end
      // lowest numbered non-empty level, NUM_LEVELS when all are empty
      resel_lvl = LVX_W'(NUM_LEVELS);
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (nonempty[i]) begin
            resel_lvl = LVX_W'(i);
         end
      end
   end

   assign cl_ok   = (int'(cl_ff) < NUM_LEVELS);
   assign cl_has  = cl_ok && nonempty[LVL_W'(cl_ff)];
   assign cnt_sel = cnt_ff[lsel_ff];
   assign cur_sel = cur_ff[lsel_ff];

   // ---- next-state logic ----
   logic [TASK_W-1:0]  req_tid;
   logic [CNT_W-1:0]   rm_cnt;
   logic [IDX_W-1:0]   rm_cur;
   logic [CNT_W-1:0]   adv_cur;
   logic               need_ins;
   logic               req_take;

   assign req_tid  = req_tdata[9:2];
   assign req_take = req_tvalid && req_tready;
   assign need_ins = !rec_act || (rec_lvl != lv_ff);

   always_comb begin
      // removal: count drops, cursor steps back if the hole was ahead of it
      rm_cnt = cnt_sel - CNT_W'(1);
      rm_cur = cur_sel - IDX_W'(row_end.prior);
      if (CNT_W'(rm_cur) >= rm_cnt) begin
         rm_cur = '0;
      end
      adv_cur = CNT_W'(cur_sel) + CNT_W'(1);
      if (adv_cur >= cnt_sel) begin
         adv_cur = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      scan_in  = scan_ff;
      clr_in   = clr_ff;
      op_in    = op_ff;
      tid_in   = tid_ff;
      tok_in   = tok_ff;
      lvraw_in = lvraw_ff;
      nslc_in  = nslc_ff;
      lv_in    = lv_ff;
      lsel_in  = lsel_ff;
      had_in   = had_ff;
      now_in   = now_ff;
      cl_in    = cl_ff;
      chg_in   = chg_ff;
      cnt_in   = cnt_ff;
      cur_in   = cur_ff;
      otask_in = otask_ff;
      oslc_in  = oslc_ff;
      oload_in = oload_ff;
      osw_in   = osw_ff;
      ostat_in = ostat_ff;

      mem_ra = TADDR_W'(tid_ff);
      mem_we = 1'b0;
      mem_wa = TADDR_W'(tid_ff);
      mem_wd = '0;

      cmd.op      = CELL_HOLD;
      cmd.level   = LVL_MAX_W'(lsel_ff);
      cmd.task_id = tid_ff;
      cmd.count   = CNT_MAX_W'(cnt_sel);
      cmd.cursor  = IDX_MAX_W'(cur_sel);

      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            clr_in = clr_ff + TADDR_W'(1);
            if (clr_ff == TADDR_W'(NUM_TASKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            mem_ra     = TADDR_W'(req_tid);
            if (req_take) begin
               op_in    = req_tdata[1:0];
               tid_in   = req_tid;
               tok_in   = (int'(req_tid) < NUM_TASKS);
               lvraw_in = req_tdata[13:10];
               nslc_in  = req_tdata[21:14];
               otask_in = '0;
               oslc_in  = '0;
               oload_in = 1'b0;
               osw_in   = 1'b0;
               ostat_in = 1'b0;
               had_in   = 1'b0;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_FIN_SET;
            unique case (op_ff)
               OP_RUN: begin
                  if (tok_ff) begin
                     if (lvraw_ff[LEVEL_W-1]) begin
                        lv_in = rec_lvl;
                     end else if (int'(lvraw_ff[LEVEL_W-2:0]) >= NUM_LEVELS) begin
                        lv_in = LVL_W'(NUM_LEVELS - 1);
                     end else begin
                        lv_in = LVL_W'(lvraw_ff[LEVEL_W-2:0]);
                     end
                     lsel_in  = lv_in;
                     state_in = S_RUN_CHK;
                  end
               end
               OP_SLEEP: begin
                  if (tok_ff && rec_act) begin
                     state_in = S_SCAN;
                     if (cl_has) begin
                        // look up the running task first
                        had_in  = 1'b1;
                        lsel_in = LVL_W'(cl_ff);
                        ret_in  = S_SL_NOW;
                     end else begin
                        lsel_in = rec_lvl;
                        ret_in  = S_SL_SHIFT;
                     end
                  end
               end
               OP_SWITCH: begin
                  oload_in = 1'b1;
                  if (cl_has) begin
                     had_in   = 1'b1;
                     lsel_in  = LVL_W'(cl_ff);
                     ret_in   = S_SW_ADV;
                     state_in = S_SCAN;
                  end else begin
                     state_in = S_SW_ADV;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            // results settle at the row end one hop a cycle
            scan_in = scan_ff + IDX_W'(1);
            if (scan_ff == IDX_W'(TASKS_PER_LEVEL - 1)) begin
               scan_in  = '0;
               state_in = ret_ff;
            end
         end
         S_RUN_CHK: begin
            if (need_ins && (cnt_sel >= CNT_W'(TASKS_PER_LEVEL))) begin
               ostat_in = 1'b1;
               state_in = S_FIN_SET;
            end else if (rec_act && (rec_lvl != lv_ff)) begin
               lsel_in  = rec_lvl;
               ret_in   = S_RUN_SHIFT;
               state_in = S_SCAN;
            end else begin
               state_in = S_RUN_INS;
            end
         end
         S_RUN_SHIFT: begin
            if (row_end.found) begin
               cmd.op           = CELL_SHIFT;
               cnt_in[lsel_ff]  = rm_cnt;
               cur_in[lsel_ff]  = rm_cur;
            end
            lsel_in  = lv_ff;
            state_in = S_RUN_INS;
         end
         S_RUN_INS: begin
            if (need_ins) begin
               cmd.op          = CELL_WRITE;
               cnt_in[lsel_ff] = cnt_sel + CNT_W'(1);
            end
            mem_we   = 1'b1;
            mem_wd   = {1'b1, lv_ff, (nslc_ff != '0) ? nslc_ff : rec_slc};
            chg_in   = 1'b1;
            state_in = S_FIN_SET;
         end
         S_SL_NOW: begin
            now_in   = row_end.pick;
            lsel_in  = rec_lvl;
            ret_in   = S_SL_SHIFT;
            state_in = S_SCAN;
         end
         S_SL_SHIFT: begin
            if (row_end.found) begin
               cmd.op          = CELL_SHIFT;
               cnt_in[lsel_ff] = rm_cnt;
               cur_in[lsel_ff] = rm_cur;
            end
            mem_we = 1'b1;
            mem_wd = {1'b0, rec_lvl, rec_slc};
            if (had_ff && (now_ff == tid_ff)) begin
               state_in = S_SL_RESEL;
            end else begin
               state_in = S_FIN_SET;
            end
         end
         S_SL_RESEL: begin
            cl_in    = resel_lvl;
            chg_in   = 1'b0;
            osw_in   = (int'(resel_lvl) < NUM_LEVELS);
            state_in = S_FIN_SET;
         end
         S_SW_ADV: begin
            if (had_ff) begin
               now_in          = row_end.pick;
               cur_in[lsel_ff] = IDX_W'(adv_cur);
            end
            if (chg_ff) begin
               cl_in  = resel_lvl;
               chg_in = 1'b0;
            end
            state_in = S_FIN_SET;
         end
         S_FIN_SET: begin
            if (cl_has) begin
               lsel_in  = LVL_W'(cl_ff);
               ret_in   = S_FIN_GOT;
               state_in = S_SCAN;
            end else begin
               otask_in = '0;
               state_in = S_OUT;
            end
         end
         S_FIN_GOT: begin
            otask_in = row_end.pick;
            if (op_ff == OP_SWITCH) begin
               mem_ra   = TADDR_W'(row_end.pick);
               osw_in   = !had_ff || (row_end.pick != now_ff);
               state_in = S_FIN_SLC;
            end else begin
               state_in = S_OUT;
            end
         end
         S_FIN_SLC: begin
            oslc_in  = rec_slc;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ret_ff   <= S_IDLE;
         scan_ff  <= '0;
         clr_ff   <= '0;
         cl_ff    <= '0;
         chg_ff   <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            cnt_ff[i] <= '0;
            cur_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         scan_ff  <= scan_in;
         clr_ff   <= clr_in;
         cl_ff    <= cl_in;
         chg_ff   <= chg_in;
         cnt_ff   <= cnt_in;
         cur_ff   <= cur_in;
      end
      op_ff    <= op_in;
      tid_ff   <= tid_in;
      tok_ff   <= tok_in;
      lvraw_ff <= lvraw_in;
      nslc_ff  <= nslc_in;
      lv_ff    <= lv_in;
      lsel_ff  <= lsel_in;
      had_ff   <= had_in;
      now_ff   <= now_in;
      otask_ff <= otask_in;
      oslc_ff  <= oslc_in;
      oload_ff <= oload_in;
      osw_ff   <= osw_in;
      ostat_ff <= ostat_in;
   end

   assign rsp_tdata = {5'b0, ostat_ff, osw_ff, oload_ff, oslc_ff, otask_ff};

endmodule

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multilevel round-robin scheduler: drives run,
// sleep and switch items with random gaps and stalls, predicts each result
// from a private copy of the task table and level queues, and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import mrrs_pkg::*;

   localparam int NTASK  = DEF_NUM_TASKS;
   localparam int NLVL   = DEF_NUM_LEVELS;
   localparam int DEPTH  = DEF_TASKS_PER_LEVEL;
   localparam int IDLE_LIMIT = 20000;   // cycles without any handshake on either side
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // lowest field last so the struct lines up with rsp_tdata
   typedef struct packed {
      logic       status;
      logic       do_switch;
      logic       load_timer;
      logic [7:0] slice_ticks;
      logic [7:0] current_task;
   } sched_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   multilevel_round_robin_scheduler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Scheduler shadow state
   // ---------------------------------------------------------------------
   bit        sh_active [NTASK];
   int        sh_level  [NTASK];
   bit [7:0]  sh_slice  [NTASK];
   int        sh_queue  [NLVL][$];   // entries in order, size is the count
   int        sh_cursor [NLVL];
   int        sh_cur_level;
   bit        sh_changed;

   sched_result_type pending_results[$];
   int  errors      = 0;
   int  sent        = 0;
   int  received    = 0;
   int  full_hits   = 0;
   int  switch_hits = 0;
   int  idle_cycles = 0;
   bit  idle_on     = 1'b1;   // random gaps allowed
   bit  drain_hold  = 1'b0;   // receiver stall switched off for pressure step

   function automatic bit current_of(output int t);
      t = 0;
      if (sh_cur_level >= NLVL) return 1'b0;
      if (sh_queue[sh_cur_level].size() == 0 ||
          sh_cursor[sh_cur_level] >= sh_queue[sh_cur_level].size()) return 1'b0;
      t = sh_queue[sh_cur_level][sh_cursor[sh_cur_level]];
      return 1'b1;
   endfunction

   function automatic void pick_top_level();
      int i;
      for (i = 0; i < NLVL; i++)
         if (sh_queue[i].size() > 0) break;
      sh_cur_level = i;
      sh_changed = 1'b0;
   endfunction

   function automatic void unlink_task(int t);
      int lv, i, n;
      lv = sh_level[t];
      n = sh_queue[lv].size();
      sh_active[t] = 1'b0;
      for (i = 0; i < n; i++)
         if (sh_queue[lv][i] == t) break;
      if (i >= n) return;
      sh_queue[lv].delete(i);
      n--;
      if (i < sh_cursor[lv]) sh_cursor[lv]--;
      if (sh_cursor[lv] >= n) sh_cursor[lv] = 0;
   endfunction

   function automatic sched_result_type schedule_step(logic [1:0] op, logic [7:0] t,
                                                      logic [3:0] lraw, logic [7:0] sl);
      sched_result_type r;
      int lv, now, nt;
      bit had, need;
      r = '0;
      if (op == OP_RUN) begin
         if (lraw[3]) lv = sh_level[t];
         else lv = (lraw >= NLVL) ? NLVL - 1 : lraw;
         need = !sh_active[t] || sh_level[t] != lv;
         if (need && sh_queue[lv].size() >= DEPTH) begin
            r.status = 1'b1;
            full_hits++;
         end else begin
            if (sl != 0) sh_slice[t] = sl;
            if (sh_active[t] && sh_level[t] != lv) unlink_task(t);
            if (!sh_active[t]) begin
               sh_level[t] = lv;
               sh_queue[lv].push_back(t);
               sh_active[t] = 1'b1;
            end
            sh_changed = 1'b1;
         end
      end else if (op == OP_SLEEP) begin
         if (sh_active[t]) begin
            had = current_of(now);
            unlink_task(t);
            if (had && now == t) begin
               pick_top_level();
               if (current_of(nt)) r.do_switch = 1'b1;
            end
         end
      end else if (op == OP_SWITCH) begin
         had = current_of(now);
         if (had) begin
            lv = sh_cur_level;
            sh_cursor[lv] = (sh_cursor[lv] + 1 >= sh_queue[lv].size()) ? 0
                                                                       : sh_cursor[lv] + 1;
         end
         if (sh_changed) pick_top_level();
         r.load_timer = 1'b1;
         if (current_of(nt)) begin
            r.slice_ticks = sh_slice[nt];
            if (!had || nt != now) r.do_switch = 1'b1;
         end
      end
      if (!current_of(now)) now = 0;
      r.current_task = now[7:0];
      if (r.do_switch) switch_hits++;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("ERROR: result %0d field %s got %0d expected %0d", received, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // Sender: one item, with an optional random gap before it
   // ---------------------------------------------------------------------
   task automatic send_item(logic [1:0] op, logic [7:0] t, logic [3:0] lv, logic [7:0] sl);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, sl, lv, t, op};
      pending_results.push_back(schedule_step(op, t, lv, sl));
      sent++;
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
      // the block does not take another item until it has answered this one anyway
      @(posedge clock);
   endtask

   // Receiver: random stall bursts on tready
   initial begin
      int burst;
      @(posedge clock);
      forever begin
         if (idle_on && !drain_hold && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            burst = $urandom_range(1, 11);
            repeat (burst) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // Result checker
   always @(posedge clock) begin
      sched_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[18:0];
         received++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected", int'(rsp_tdata), 0);
         end else begin
            want = pending_results.pop_front();
            if (got.current_task != want.current_task)
               report_mismatch("current_task", got.current_task, want.current_task);
            if (got.slice_ticks != want.slice_ticks)
               report_mismatch("slice_ticks", got.slice_ticks, want.slice_ticks);
            if (got.load_timer != want.load_timer)
               report_mismatch("load_timer", got.load_timer, want.load_timer);
            if (got.do_switch != want.do_switch)
               report_mismatch("do_switch", got.do_switch, want.do_switch);
            if (got.status != want.status)
               report_mismatch("status", got.status, want.status);
         end
      end
   end

   // Watchdog: counts cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("ERROR: watchdog timeout");
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   function automatic logic [3:0] rand_level();
      // mostly valid levels, sometimes keep (-1) or another value with bit 3 set (also keep)
      case ($urandom_range(0, 9))
         0: return 4'hF;
         1: return 4'($urandom_range(8, 15));
         default: return 4'($urandom_range(0, NLVL - 1));
      endcase
   endfunction

   task automatic test_directed();
      send_item(OP_SWITCH, 8'd0, 4'd0, 8'd0);      // switch with no current task
      send_item(OP_SLEEP, 8'd5, 4'd0, 8'd0);       // sleep of an inactive task
      send_item(OP_RUN, 8'd0, 4'd0, 8'd255);
      send_item(OP_RUN, 8'd255, 4'd7, 8'd1);
      send_item(OP_RUN, 8'd170, 4'd15, 8'd0);      // keep level, keep slice
      send_item(OP_RUN, 8'd85, 4'd12, 8'd9);       // bit 3 set, so the level is kept
      send_item(OP_SWITCH, 8'd0, 4'd0, 8'd0);
      send_item(OP_SWITCH, 8'd0, 4'd0, 8'd0);
      send_item(OP_RUN, 8'd0, 4'd0, 8'd33);        // active task at same level
      send_item(OP_RUN, 8'd0, 4'd3, 8'd0);         // move an active task to another level
      send_item(OP_SWITCH, 8'd0, 4'd0, 8'd0);
      send_item(OP_UNUSED, 8'd255, 4'd15, 8'd255); // unused op
      send_item(OP_SLEEP, 8'd170, 4'd0, 8'd0);     // current task sleeps
      send_item(OP_SWITCH, 8'd0, 4'd0, 8'd0);
      send_item(OP_SLEEP, 8'd255, 4'd0, 8'd0);
      send_item(OP_SLEEP, 8'd85, 4'd0, 8'd0);
      send_item(OP_SLEEP, 8'd0, 4'd0, 8'd0);
      send_item(OP_SWITCH, 8'd0, 4'd0, 8'd0);
   endtask

   // fill level 2 past its depth so the insert is refused
   task automatic test_full_level();
      for (int i = 0; i <= DEPTH + 1; i++)
         send_item(OP_RUN, 8'(i + 16), 4'd2, 8'($urandom_range(0, 255)));
      send_item(OP_SWITCH, 8'd0, 4'd0, 8'd0);
      for (int i = 0; i < DEPTH / 2; i++)
         send_item(OP_SLEEP, 8'($urandom_range(16, 16 + DEPTH)), 4'd0, 8'd0);
   endtask

   // the sender holds off until every result is back
   task automatic test_drain_pause();
      drain_hold = 1'b1;
      while (pending_results.size() != 0) @(posedge clock);
      drain_hold = 1'b0;
      send_item(OP_SWITCH, 8'd0, 4'd0, 8'd0);
   endtask

   task automatic test_random(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 9);
         if (k < 4)
            send_item(OP_RUN, 8'($urandom_range(0, 63) + (k == 0 ? 192 : 0)),
                      rand_level(), 8'($urandom_range(0, 255)));
         else if (k < 6)
            send_item(OP_SLEEP, 8'($urandom_range(0, 63) + (k == 4 ? 192 : 0)),
                      4'($urandom), 8'($urandom));
         else if (k < 9)
            send_item(OP_SWITCH, 8'($urandom), 4'($urandom), 8'($urandom));
         else
            send_item(OP_UNUSED, 8'($urandom), 4'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      foreach (sh_level[i]) begin
         sh_active[i] = 1'b0;
         sh_level[i] = 0;
         sh_slice[i] = '0;
      end
      foreach (sh_cursor[i]) sh_cursor[i] = 0;
      sh_cur_level = 0;
      sh_changed = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_level();
      test_drain_pause();
      test_random(1500);
      idle_on = 1'b0;                  // last part runs at full rate
      test_random(200);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3 * DEPTH + 20) @(posedge clock);
      $display("Covered %0d items, %0d results, %0d full-level refusals, %0d task switches",
               sent, received, full_hits, switch_hits);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
sv/mrrs_pkg.sv
sv/mrrs_cell.sv
sv/multilevel_round_robin_scheduler.sv
test/tb_top.sv
